### rtl/pts_pkg.sv
// Shared types, sizes and helper functions of the polynomial trajectory sampler.
`default_nettype none
package pts_pkg;

	// Store geometry.
	localparam int MAX_SEGMENTS = 16;
	localparam int NUM_COEFFS   = 8;
	localparam int NUM_AXES     = 3;
	localparam int MEM_DEPTH    = MAX_SEGMENTS * NUM_COEFFS;
	localparam int MEM_AW       = $clog2(MEM_DEPTH);
	localparam int CIDX_W       = $clog2(NUM_COEFFS);

	// Field and datapath widths.
	localparam int MODE_W   = 2;
	localparam int SEG_W    = 4;
	localparam int AXIS_W   = 2;
	localparam int POW_W    = 3;
	localparam int DATA_W   = 32;
	localparam int T_W      = 24;
	localparam int FRAC_W   = 16;
	localparam int VAL_W    = 48;
	localparam int WEIGHT_W = 8;
	localparam int PROD_W   = VAL_W + T_W - FRAC_W;
	localparam int CW_W     = DATA_W + WEIGHT_W + 1;
	localparam int SUM_W    = PROD_W + 2;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_VEL  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ACC  = 2'd3;

	// Derivative orders.
	localparam logic [1:0] ORD_POS = 2'd0;
	localparam logic [1:0] ORD_VEL = 2'd1;
	localparam logic [1:0] ORD_ACC = 2'd2;

	// Clipping bounds of the Q32.16 accumulator, widened to the sum width.
	localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_LO = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} state_t;

	// Derivative weight of coefficient j: 1, j or j*(j-1).
	function automatic logic [WEIGHT_W-1:0] weight(input logic [CIDX_W-1:0] j,
			input logic [1:0] order);
		logic [WEIGHT_W-1:0] w;
		case (order)
			ORD_POS: w = WEIGHT_W'(1);
			ORD_VEL: w = WEIGHT_W'(j);
			ORD_ACC: w = WEIGHT_W'(32'(j) * (32'(j) - 32'd1));
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

### rtl/poly_trajectory_sampler_unit.sv
// Top level of the polynomial trajectory sampler: coefficient store and Horner sequencer.
`default_nettype none
// A load beat writes one Q16.16 coefficient into a per-axis store and presents an all-zero
// result from the done state once the output register is free. An evaluate beat runs
// Horner's rule on the three axes in parallel, one shared multiply-add per axis, with a
// store read first and then a multiply step and an add-and-clip step per coefficient. The
// derivative order d sets how far the loop runs: from the top coefficient down to
// coefficient d. cmd_stall is high while an item is in progress; the finished result
// sits in an output register, so the next beat is taken while it waits. The store needs
// no clearing after reset.
module poly_trajectory_sampler_unit
	import pts_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// Command channel
	input  wire logic                     cmd_valid,
	output logic                          cmd_stall,
	input  wire logic [MODE_W-1:0]        mode,
	input  wire logic [SEG_W-1:0]         segment,
	input  wire logic [AXIS_W-1:0]        axis,
	input  wire logic [POW_W-1:0]         power_index,
	input  wire logic signed [DATA_W-1:0] coeff_value,
	input  wire logic [T_W-1:0]           local_time,
	// Result channel
	output logic                          res_valid,
	input  wire logic                     res_stall,
	output logic signed [VAL_W-1:0]       x_value,
	output logic signed [VAL_W-1:0]       y_value,
	output logic signed [VAL_W-1:0]       z_value,
	output logic                          saturated
);

	state_t state_q, state_d;

	logic                    cmd_accept;
	logic                    out_free;
	logic                    eval_skip;
	logic                    last_step;
	logic                    rd_en, mul_en, add_en, res_load;

	logic [SEG_W-1:0]        seg_q;
	logic [1:0]              order_q;
	logic [T_W-1:0]          t_q;
	logic [CIDX_W-1:0]       j_q;
	logic [CIDX_W-1:0]       rd_j;
	logic [MEM_AW-1:0]       wr_idx, rd_idx;

	logic [DATA_W-1:0]       mem [NUM_AXES][MEM_DEPTH];
	logic [DATA_W-1:0]       rd_q [NUM_AXES];

	logic signed [VAL_W-1:0] acc_q [NUM_AXES];
	logic                    sat_q;

	logic [PROD_W-1:0]       prod_s1 [NUM_AXES];
	logic                    neg_s1 [NUM_AXES];
	logic signed [CW_W-1:0]  cw_s1 [NUM_AXES];

	logic [PROD_W-1:0]       prod_c [NUM_AXES];
	logic signed [CW_W-1:0]  cw_c [NUM_AXES];
	logic signed [VAL_W-1:0] acc_c [NUM_AXES];
	logic [NUM_AXES-1:0]     clip_c;

	logic signed [VAL_W-1:0] x_q, y_q, z_q;
	logic                    sat_out_q, res_valid_q;

	// Handshake terms.
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign last_step  = (32'(j_q) == 32'(order_q));

	// Loads, segments beyond the store and polynomials too short for the derivative skip Horner.
	assign eval_skip = (mode == MODE_LOAD) || (32'(segment) >= MAX_SEGMENTS) ||
		((32'(mode) - 32'd1) >= NUM_COEFFS);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = eval_skip ? ST_DONE : ST_READ;
				end
			end
			ST_READ: state_d = ST_MUL;
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = last_step ? ST_DONE : ST_MUL;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs decoded from the state.
	always_comb begin
		cmd_stall = 1'b1;
		rd_en     = 1'b0;
		mul_en    = 1'b0;
		add_en    = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			ST_IDLE: cmd_stall = 1'b0;
			ST_READ: rd_en = 1'b1;
			ST_MUL:  mul_en = 1'b1;
			ST_ADD: begin
				add_en = 1'b1;
				rd_en  = 1'b1;
			end
			ST_DONE: res_load = out_free;
			default: cmd_stall = 1'b1;
		endcase
	end

	// Sequencer state and coefficient counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_accept) begin
				j_q <= CIDX_W'(NUM_COEFFS - 1);
			end else if (add_en && !last_step) begin
				j_q <= j_q - 1'b1;
			end
		end
	end

	// Item fields held for the whole evaluation.
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			seg_q   <= segment;
			order_q <= mode - 2'd1;
			t_q     <= local_time;
		end
	end

	// Store addressing: the add cycle already fetches the next lower coefficient.
	assign rd_j   = add_en ? (j_q - 1'b1) : j_q;
	assign wr_idx = MEM_AW'(32'(segment) * NUM_COEFFS + 32'(power_index));
	assign rd_idx = MEM_AW'(32'(seg_q) * NUM_COEFFS + 32'(rd_j));

	// Coefficient store, one bank per axis, with registered read data.
	always_ff @(posedge clk) begin
		for (int a = 0; a < NUM_AXES; a++) begin
			if (cmd_accept && (mode == MODE_LOAD) && (32'(segment) < MAX_SEGMENTS) &&
					(32'(axis) == a) && (32'(power_index) < NUM_COEFFS)) begin
				mem[a][wr_idx] <= coeff_value;
			end
			if (rd_en) begin
				rd_q[a] <= mem[a][rd_idx];
			end
		end
	end

	// Multiply phase: |acc| * t rounded half up to Q.16, and the weighted coefficient.
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			logic [VAL_W-1:0]        mag;
			logic [VAL_W+FRAC_W-1:0] p_lo;
			logic [PROD_W-1:0]       p_hi;
			mag     = acc_q[a][VAL_W-1] ? (~acc_q[a] + 1'b1) : acc_q[a];
			p_lo    = mag * t_q[FRAC_W-1:0];
			p_hi    = mag * t_q[T_W-1:FRAC_W];
			prod_c[a] = p_hi + PROD_W'((p_lo + (VAL_W+FRAC_W)'(32'h8000)) >> FRAC_W);
			cw_c[a] = $signed(rd_q[a]) * $signed({1'b0, weight(j_q, order_q)});
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prod_s1[a] <= prod_c[a];
				neg_s1[a]  <= acc_q[a][VAL_W-1];
				cw_s1[a]   <= cw_c[a];
			end
		end
	end

	// Add phase: restore the sign, add the weighted coefficient and clip to Q32.16.
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			logic signed [SUM_W-1:0] p_ext;
			logic signed [SUM_W-1:0] cw_ext;
			logic signed [SUM_W-1:0] sum;
			p_ext  = {2'b00, prod_s1[a]};
			cw_ext = {{(SUM_W-CW_W){cw_s1[a][CW_W-1]}}, cw_s1[a]};
			sum    = neg_s1[a] ? (cw_ext - p_ext) : (cw_ext + p_ext);
			if (sum > SUM_HI) begin
				acc_c[a]  = SUM_HI[VAL_W-1:0];
				clip_c[a] = 1'b1;
			end else if (sum < SUM_LO) begin
				acc_c[a]  = SUM_LO[VAL_W-1:0];
				clip_c[a] = 1'b1;
			end else begin
				acc_c[a]  = sum[VAL_W-1:0];
				clip_c[a] = 1'b0;
			end
		end
	end

	// Accumulators start at zero for every item, so skipped items report zero.
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				acc_q[a] <= '0;
			end
			sat_q <= 1'b0;
		end else if (add_en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				acc_q[a] <= acc_c[a];
			end
			sat_q <= sat_q | (|clip_c);
		end
	end

	// Output register of the result channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			x_q       <= acc_q[0];
			y_q       <= acc_q[1];
			z_q       <= acc_q[2];
			sat_out_q <= sat_q;
		end
	end

	assign res_valid = res_valid_q;
	assign x_value   = x_q;
	assign y_value   = y_q;
	assign z_value   = z_q;
	assign saturated = sat_out_q;

endmodule
`default_nettype wire

### rtl/pts_checker.sv
// Port-level checker of the polynomial trajectory sampler and its bind.
`default_nettype none
module pts_port_checker
	import pts_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     cmd_valid,
	input wire logic                     cmd_stall,
	input wire logic                     res_valid,
	input wire logic                     res_stall,
	input wire logic signed [VAL_W-1:0]  x_value,
	input wire logic signed [VAL_W-1:0]  y_value,
	input wire logic signed [VAL_W-1:0]  z_value,
	input wire logic                     saturated
);

	// An accepted beat keeps the block busy for at least the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command channel open straight after an accepted beat");

	// A fresh result only appears at the end of a busy period.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result appeared while the block was idle");

	// The block only becomes ready again once its result is on display.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(cmd_stall) |-> res_valid)
		else $error("block went idle without presenting a result");

	// A stalled result beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(x_value) && $stable(y_value) &&
			$stable(z_value) && $stable(saturated)))
		else $error("stalled result beat changed");

endmodule

bind poly_trajectory_sampler_unit pts_port_checker u_pts_port_checker (.*);
`default_nettype wire
